// ===== sv/cef_pkg.sv =====
// Shared types and constants for the 3x3 clamped-edge convolution filter.
// No dependencies.
package cef_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam int PROD_W = 25;
  localparam int PSUM_W = 27;
  localparam int ACC_W = 29;

  localparam logic [CFG_IDX_W-1:0] REG_KTOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KMID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KBOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [31:0] pix_t;
  typedef logic signed [15:0] coef_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;
  } out_item_t;

  // one stream position on its way into the window stage
  typedef struct packed {
    logic valid;
    logic flush;     // sample comes from the newer row store (bottom repeat)
    logic emit;
    logic last;
    logic at_col0;   // emits the right-edge result of the previous row
    logic left_rep;
    logic top_rep;
    pix_t pixel;
  } adv_ctrl_t;

endpackage

// ===== sv/cef_linebuf.sv =====
// Two row stores (older and newer row) with registered reads.
// Depends on cef_pkg.
module cef_linebuf #(
  parameter int DEPTH = 2048,
  parameter int AW = 11
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   rd_addr,
  output cef_pkg::pix_t   rd_older,
  output cef_pkg::pix_t   rd_newer,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cef_pkg::pix_t   wr_older,
  input  cef_pkg::pix_t   wr_newer
);
  import cef_pkg::*;

  pix_t older_mem [DEPTH];
  pix_t newer_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_older;
      newer_mem[wr_addr] <= wr_newer;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_older <= older_mem[rd_addr];
      rd_newer <= newer_mem[rd_addr];
    end
  end

endmodule

// ===== sv/cef_window.sv =====
// 3x3 window, store write-back with forwarding, and edge-repeat tap selection.
// Depends on cef_pkg.
module cef_window #(
  parameter int AW = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cef_pkg::adv_ctrl_t s1,
  input  logic [AW-1:0]     s1_addr,
  input  cef_pkg::pix_t     rd_older,
  input  cef_pkg::pix_t     rd_newer,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output cef_pkg::pix_t     wr_older,
  output cef_pkg::pix_t     wr_newer,
  output cef_pkg::pix_t     taps [9],
  output logic              tap_valid,
  output logic              tap_last
);
  import cef_pkg::*;

  pix_t win [9];
  pix_t nw [9];
  pix_t t [9];
  logic fwd_valid;
  logic [AW-1:0] fwd_addr;
  pix_t fwd_older;
  pix_t fwd_newer;
  logic hit;
  pix_t older_v;
  pix_t newer_v;
  pix_t pix_v;

  // a write at the same edge as our read is not yet visible in the read data
  assign hit = fwd_valid && (fwd_addr == s1_addr);
  assign older_v = hit ? fwd_older : rd_older;
  assign newer_v = hit ? fwd_newer : rd_newer;
  assign pix_v = s1.flush ? newer_v : s1.pixel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i*3]   = win[i*3+1];
      nw[i*3+1] = win[i*3+2];
    end
    nw[2] = older_v;
    nw[5] = newer_v;
    nw[8] = pix_v;
    for (int i = 0; i < 3; i++) begin
      if (s1.at_col0) begin
        t[i*3+1] = win[i*3+2];
        t[i*3+2] = win[i*3+2];
        t[i*3]   = s1.left_rep ? win[i*3+2] : win[i*3+1];
      end else begin
        t[i*3+1] = nw[i*3+1];
        t[i*3+2] = nw[i*3+2];
        t[i*3]   = s1.left_rep ? nw[i*3+1] : nw[i*3];
      end
    end
    if (s1.top_rep) begin
      for (int i = 0; i < 3; i++) t[i] = t[3+i];
    end
  end

  assign wr_en = en && s1.valid;
  assign wr_addr = s1_addr;
  assign wr_older = newer_v;
  assign wr_newer = pix_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      tap_valid <= 1'b0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (en) begin
      fwd_valid <= s1.valid;
      tap_valid <= s1.valid && s1.emit;
      if (s1.valid) begin
        for (int i = 0; i < 9; i++) win[i] <= nw[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_addr <= s1_addr;
      fwd_older <= newer_v;
      fwd_newer <= pix_v;
      tap_last <= s1.last;
      for (int i = 0; i < 9; i++) taps[i] <= t[i];
    end
  end

endmodule

// ===== sv/cef_lane.sv =====
// One channel lane: nine products, two-level adder, clamp to 0..255.
// Depends on cef_pkg.
module cef_lane #(
  parameter int FRAC = 12
) (
  input  logic           clk,
  input  logic           en,
  input  logic [7:0]     smp [9],
  input  cef_pkg::coef_t coef [9],
  output logic [7:0]     res
);
  import cef_pkg::*;

  logic signed [PROD_W-1:0] prod [9];
  logic signed [PSUM_W-1:0] psum [3];
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) prod[i] <= coef[i] * $signed({1'b0, smp[i]});
      for (int j = 0; j < 3; j++) begin
        psum[j] <= PSUM_W'(prod[j*3]) + PSUM_W'(prod[j*3+1]) + PSUM_W'(prod[j*3+2]);
      end
      acc <= ACC_W'(psum[0]) + ACC_W'(psum[1]) + ACC_W'(psum[2]);
    end
  end

  // floor by arithmetic shift; negative sums clamp to zero
  assign q = ACC_W'(acc >>> FRAC);

  always_comb begin
    if (acc[ACC_W-1]) begin
      res = 8'd0;
    end else if (q > ACC_W'(255)) begin
      res = 8'd255;
    end else begin
      res = q[7:0];
    end
  end

endmodule

// ===== sv/conv3x3_clamped_edge_filter.sv =====
// Top level: stream position control, row stores, window, four channel lanes.
// Depends on cef_pkg, cef_linebuf, cef_window, cef_lane.
//
//   port group   handshake              payload
//   src          src_valid / src_stall  src_item  (in_item_t)
//   res          res_valid / res_stall  res_item  (out_item_t)
//   cfg          cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock unless stalled; each result leaves from the res_item register.
// The one exception: on a one-row frame the first flush makes two window steps
// and holds src_stall for the second (row store read then write-back).
// rst is synchronous; the row stores are not cleared and need no sweep.
// res_stall with res_valid high freezes the whole pipeline; src_stall follows it in the same cycle.
module conv3x3_clamped_edge_filter #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                src_valid,
  output logic                                src_stall,
  input  cef_pkg::in_item_t                   src_item,
  output logic                                res_valid,
  input  logic                                res_stall,
  output cef_pkg::out_item_t                  res_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cef_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cef_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cef_pkg::*;

  localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int FSW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int FSW1 = FSW + 1;

  logic [CFG_DATA_W-1:0] kernel_row_top;
  logic [CFG_DATA_W-1:0] kernel_row_middle;
  logic [CFG_DATA_W-1:0] kernel_row_bottom;
  logic [11:0]           image_width;
  logic [12:0]           image_height;

  logic [CW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;
  logic [FSW-1:0]  fsize;
  logic [COLW-1:0] col;
  logic [RW-1:0]   row;
  logic [FSW-1:0]  cnt;
  logic            extra;

  logic            en;
  logic            take;
  logic            is_flush;
  logic            row_done;
  logic            adv_item;
  logic            launch;
  logic            emit;
  logic            last;
  logic            size_wr;
  logic [CW-1:0]   col_inc;
  adv_ctrl_t       ctrl;
  adv_ctrl_t       s1;
  logic [COLW-1:0] s1_addr;

  pix_t            rd_older;
  pix_t            rd_newer;
  logic            wr_en;
  logic [COLW-1:0] wr_addr;
  pix_t            wr_older;
  pix_t            wr_newer;
  pix_t            taps [9];
  logic            tap_valid;
  logic            tap_last;
  coef_t           coef [9];
  logic [7:0]      lane_res [4];
  logic            vp, vs, va;
  logic            lp, ls, la;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;
  assign size_wr = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_row_top <= '0;
      kernel_row_middle <= 48'h0000_1000_0000;
      kernel_row_bottom <= '0;
      image_width <= 12'd2048;
      image_height <= 13'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KTOP:   kernel_row_top <= cfg_data;
        REG_KMID:   kernel_row_middle <= cfg_data;
        REG_KBOT:   kernel_row_bottom <= cfg_data;
        REG_WIDTH:  image_width <= cfg_data[11:0];
        REG_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      eff_w = CW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height);
    end
  end

  always_ff @(posedge clk) begin
    fsize <= FSW'(eff_w) * FSW'(eff_h);
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      case (i / 3)
        0:       coef[i] = kernel_row_top[16*(i%3) +: 16];
        1:       coef[i] = kernel_row_middle[16*(i%3) +: 16];
        default: coef[i] = kernel_row_bottom[16*(i%3) +: 16];
      endcase
    end
  end

  // ---------------- stream position ----------------
  assign en = !(res_valid && res_stall);
  assign src_stall = !en || extra;
  assign take = src_valid && !src_stall;
  assign is_flush = (src_item.opcode == OP_FLUSH);
  assign row_done = (32'(row) >= 32'(eff_h));
  assign adv_item = take && (is_flush ? row_done : !row_done);
  assign launch = adv_item || (extra && en);
  assign emit = (row >= RW'(2)) || (row == RW'(1) && col != '0);
  assign last = emit && ((FSW1'(cnt) + FSW1'(1)) >= FSW1'(fsize));
  assign col_inc = CW'(col) + CW'(1);

  always_comb begin
    ctrl.valid = launch;
    ctrl.flush = is_flush || extra;
    ctrl.emit = emit;
    ctrl.last = last;
    ctrl.at_col0 = (col == '0);
    ctrl.left_rep = (col == '0) ? (eff_w == CW'(1)) : (col == COLW'(1));
    ctrl.top_rep = (col == '0) ? (row == RW'(2)) : (row == RW'(1));
    ctrl.pixel = {src_item.in_alpha, src_item.in_blue, src_item.in_green, src_item.in_red};
  end

  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      col <= '0;
      row <= '0;
      cnt <= '0;
      extra <= 1'b0;
    end else begin
      if (launch) begin
        if (last) begin
          col <= '0;
          row <= '0;
          cnt <= '0;
        end else begin
          if (emit) cnt <= cnt + FSW'(1);
          if (col_inc >= eff_w) begin
            col <= '0;
            row <= row + RW'(1);
          end else begin
            col <= COLW'(col_inc);
          end
        end
      end
      // single-row frame: the first flush step yields nothing, a second follows
      if (adv_item && is_flush && !emit) begin
        extra <= 1'b1;
      end else if (extra && en) begin
        extra <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= launch;
    end
    if (en) begin
      s1.flush <= ctrl.flush;
      s1.emit <= ctrl.emit;
      s1.last <= ctrl.last;
      s1.at_col0 <= ctrl.at_col0;
      s1.left_rep <= ctrl.left_rep;
      s1.top_rep <= ctrl.top_rep;
      s1.pixel <= ctrl.pixel;
      s1_addr <= col;
    end
  end

  // ---------------- row stores and window ----------------
  cef_linebuf #(
    .DEPTH(MAX_WIDTH),
    .AW(COLW)
  ) u_linebuf (
    .clk(clk),
    .en(en),
    .rd_addr(col),
    .rd_older(rd_older),
    .rd_newer(rd_newer),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_older(wr_older),
    .wr_newer(wr_newer)
  );

  cef_window #(
    .AW(COLW)
  ) u_window (
    .clk(clk),
    .rst(rst),
    .en(en),
    .s1(s1),
    .s1_addr(s1_addr),
    .rd_older(rd_older),
    .rd_newer(rd_newer),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_older(wr_older),
    .wr_newer(wr_newer),
    .taps(taps),
    .tap_valid(tap_valid),
    .tap_last(tap_last)
  );

  // ---------------- channel lanes ----------------
  for (genvar ch = 0; ch < 4; ch++) begin : g_lane
    logic [7:0] smp [9];
    always_comb begin
      for (int i = 0; i < 9; i++) smp[i] = taps[i][8*ch +: 8];
    end
    cef_lane #(
      .FRAC(COEF_FRAC_BITS)
    ) u_lane (
      .clk(clk),
      .en(en),
      .smp(smp),
      .coef(coef),
      .res(lane_res[ch])
    );
  end

  // ---------------- merge and output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
      vs <= 1'b0;
      va <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      vp <= tap_valid;
      vs <= vp;
      va <= vs;
      res_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lp <= tap_last;
      ls <= lp;
      la <= ls;
      res_item.out_red <= lane_res[0];
      res_item.out_green <= lane_res[1];
      res_item.out_blue <= lane_res[2];
      res_item.out_alpha <= lane_res[3];
      res_item.frame_end <= la;
    end
  end

endmodule
